// ===== rtl/core/ufwf_pkg.sv =====
// ----------------------------------------------------------------------------
// ufwf_pkg
// Shared types, codes and constants of the serial flash write framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ufwf_pkg;

   // chunk store geometry
   localparam int MAX_CHUNK = 62;
   localparam int IDX_W     = $clog2(MAX_CHUNK);
   localparam int FILL_W    = $clog2(MAX_CHUNK + 1);

   // csr geometry
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // register indexes
   localparam logic [1:0] REG_START_ADDRESS = 2'd0;
   localparam logic [1:0] REG_CHUNK_SIZE    = 2'd1;
   localparam logic [1:0] REG_ACK_CODE      = 2'd2;
   localparam logic [1:0] REG_WRITE_OPCODE  = 2'd3;

   // register reset values
   localparam logic [31:0] RST_START_ADDRESS = 32'h0800_0000;
   localparam logic [5:0]  RST_CHUNK_SIZE    = 6'd6;
   localparam logic [7:0]  RST_ACK_CODE      = 8'h79;
   localparam logic [7:0]  RST_WRITE_OPCODE  = 8'h31;

   // operation codes
   localparam logic [1:0] OP_IMAGE = 2'd0;
   localparam logic [1:0] OP_REPLY = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // result status codes
   localparam logic [2:0] ST_ACCEPTED = 3'd0;
   localparam logic [2:0] ST_SENDING  = 3'd1;
   localparam logic [2:0] ST_CHUNK    = 3'd2;
   localparam logic [2:0] ST_DONE     = 3'd3;
   localparam logic [2:0] ST_ERROR    = 3'd4;
   localparam logic [2:0] ST_BUSY     = 3'd5;

   // transmit byte sources
   localparam logic [3:0] SEL_NONE  = 4'd0;
   localparam logic [3:0] SEL_OPC   = 4'd1;
   localparam logic [3:0] SEL_NOPC  = 4'd2;
   localparam logic [3:0] SEL_A3    = 4'd3;
   localparam logic [3:0] SEL_A2    = 4'd4;
   localparam logic [3:0] SEL_A1    = 4'd5;
   localparam logic [3:0] SEL_A0    = 4'd6;
   localparam logic [3:0] SEL_AXOR  = 4'd7;
   localparam logic [3:0] SEL_NM1   = 4'd8;
   localparam logic [3:0] SEL_DATA  = 4'd9;
   localparam logic [3:0] SEL_SUM   = 4'd10;

   localparam logic [7:0] BYTE_MASK = 8'hFF;

   // commands from controller to datapath
   typedef struct packed {
      logic       out_load;
      logic [3:0] out_sel;
      logic [2:0] out_status;
      logic       out_last;
      logic       start;
      logic       store;
      logic       set_final;
      logic       advance;
      logic       idx_inc;
      logic       idx_clear;
      logic       sum_init;
      logic       sum_acc;
   } ufwf_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic out_free;
      logic chunk_full;
      logic ack_match;
      logic final_chunk;
      logic data_last;
   } ufwf_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/ufwf_ram.sv =====
// ----------------------------------------------------------------------------
// ufwf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufwf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 62
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/ufwf_dp.sv =====
// ----------------------------------------------------------------------------
// ufwf_dp
// Datapath: csr registers, address and fill tracking, checksum, output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufwf_dp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ufwf_pkg::ufwf_cmd_type      cmd,
   output ufwf_pkg::ufwf_stat_type          stat,
   // input payload
   input  wire logic [7:0]                  req_data_byte,
   input  wire logic                        req_last_of_image,
   // chunk store
   output logic                             ram_wr_en,
   output logic [ufwf_pkg::IDX_W-1:0]       ram_wr_addr,
   output logic [7:0]                       ram_wr_data,
   output logic [ufwf_pkg::IDX_W-1:0]       ram_rd_addr,
   input  wire logic [7:0]                  ram_rd_data,
   // result channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [7:0]                       rsp_tx_byte,
   output logic                             rsp_tx_valid,
   output logic [2:0]                       rsp_status,
   output logic                             rsp_last_result,
   // csr port
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [ufwf_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [ufwf_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [ufwf_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                             csr_pready
);
   import ufwf_pkg::*;

   logic [31:0]       start_address_ff, start_address_in;
   logic [5:0]        chunk_size_ff, chunk_size_in;
   logic [7:0]        ack_code_ff, ack_code_in;
   logic [7:0]        write_opcode_ff, write_opcode_in;
   logic [31:0]       address_ff, address_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              final_ff, final_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [7:0]        sum_ff, sum_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        tx_byte_ff, tx_byte_in;
   logic              tx_valid_ff, tx_valid_in;
   logic [2:0]        status_ff, status_in;
   logic              last_ff, last_in;

   logic              csr_write;
   logic [1:0]        csr_index;
   logic [5:0]        limit;
   logic [FILL_W-1:0] fill_next;
   logic              room;
   logic [7:0]        nm1;
   logic [7:0]        addr_xor;

   // csr access, index by word address
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      start_address_in = start_address_ff;
      chunk_size_in    = chunk_size_ff;
      ack_code_in      = ack_code_ff;
      write_opcode_in  = write_opcode_ff;
      if (csr_write) begin
         case (csr_index)
            REG_START_ADDRESS: start_address_in = csr_pwdata;
            REG_CHUNK_SIZE:    chunk_size_in    = csr_pwdata[5:0];
            REG_ACK_CODE:      ack_code_in      = csr_pwdata[7:0];
            REG_WRITE_OPCODE:  write_opcode_in  = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_START_ADDRESS: csr_prdata = start_address_ff;
         REG_CHUNK_SIZE:    csr_prdata = {26'd0, chunk_size_ff};
         REG_ACK_CODE:      csr_prdata = {24'd0, ack_code_ff};
         REG_WRITE_OPCODE:  csr_prdata = {24'd0, write_opcode_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // effective chunk size, zero acts as one and oversize clamps
   always_comb begin
      if (chunk_size_ff == 6'd0) begin
         limit = 6'd1;
      end else if (chunk_size_ff > 6'(MAX_CHUNK)) begin
         limit = 6'(MAX_CHUNK);
      end else begin
         limit = chunk_size_ff;
      end
   end

   // gather bookkeeping
   assign room      = (fill_ff < FILL_W'(MAX_CHUNK));
   assign fill_next = room ? fill_ff + FILL_W'(1) : fill_ff;
   assign nm1       = 8'(fill_ff) - 8'd1;
   assign addr_xor  = address_ff[31:24] ^ address_ff[23:16] ^ address_ff[15:8]
                    ^ address_ff[7:0];

   // chunk store write at the fill position
   assign ram_wr_en   = cmd.store & room;
   assign ram_wr_addr = fill_ff[IDX_W-1:0];
   assign ram_wr_data = req_data_byte;

   always_comb begin
      address_in = address_ff;
      fill_in    = fill_ff;
      final_in   = final_ff;
      if (cmd.start) begin
         address_in = start_address_ff;
         fill_in    = '0;
         final_in   = 1'b0;
      end else if (cmd.advance) begin
         address_in = address_ff + 32'(fill_ff);
         fill_in    = '0;
         final_in   = 1'b0;
      end else if (cmd.store) begin
         fill_in = fill_next;
         if (cmd.set_final) begin
            final_in = req_last_of_image;
         end
      end
   end

   // read index runs one step ahead so registered read data matches idx_ff
   always_comb begin
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end
   assign ram_rd_addr = idx_in;

   // running data checksum
   always_comb begin
      if (cmd.sum_init) begin
         sum_in = nm1;
      end else if (cmd.sum_acc) begin
         sum_in = sum_ff ^ ram_rd_data;
      end else begin
         sum_in = sum_ff;
      end
   end

   // output stage
   always_comb begin
      case (cmd.out_sel)
         SEL_OPC:  tx_byte_in = write_opcode_ff;
         SEL_NOPC: tx_byte_in = write_opcode_ff ^ BYTE_MASK;
         SEL_A3:   tx_byte_in = address_ff[31:24];
         SEL_A2:   tx_byte_in = address_ff[23:16];
         SEL_A1:   tx_byte_in = address_ff[15:8];
         SEL_A0:   tx_byte_in = address_ff[7:0];
         SEL_AXOR: tx_byte_in = addr_xor;
         SEL_NM1:  tx_byte_in = nm1;
         SEL_DATA: tx_byte_in = ram_rd_data;
         SEL_SUM:  tx_byte_in = sum_ff;
         default:  tx_byte_in = 8'd0;
      endcase
      tx_valid_in = (cmd.out_sel != SEL_NONE);
      status_in   = cmd.out_status;
      last_in     = cmd.out_last;
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_address_ff <= RST_START_ADDRESS;
         chunk_size_ff    <= RST_CHUNK_SIZE;
         ack_code_ff      <= RST_ACK_CODE;
         write_opcode_ff  <= RST_WRITE_OPCODE;
         address_ff       <= '0;
         fill_ff          <= '0;
         final_ff         <= 1'b0;
         idx_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         start_address_ff <= start_address_in;
         chunk_size_ff    <= chunk_size_in;
         ack_code_ff      <= ack_code_in;
         write_opcode_ff  <= write_opcode_in;
         address_ff       <= address_in;
         fill_ff          <= fill_in;
         final_ff         <= final_in;
         idx_ff           <= idx_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (cmd.out_load) begin
         tx_byte_ff  <= tx_byte_in;
         tx_valid_ff <= tx_valid_in;
         status_ff   <= status_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tx_byte     = tx_byte_ff;
   assign rsp_tx_valid    = tx_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_last_result = last_ff;

   // status to controller
   assign stat.out_free    = ~rsp_valid_ff | ~rsp_stall;
   assign stat.chunk_full  = (fill_next >= FILL_W'(limit));
   assign stat.ack_match   = (req_data_byte == ack_code_ff);
   assign stat.final_chunk = final_ff;
   assign stat.data_last   = (FILL_W'(idx_ff) == fill_ff - FILL_W'(1));

   // a result is only loaded into a free output stage
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a stalled result");

   // data bytes are only read from entries of the current chunk
   assert property (@(posedge clock) disable iff (reset)
      cmd.idx_inc |-> (FILL_W'(idx_ff) < fill_ff))
      else $error("chunk read beyond fill count");

endmodule

`default_nettype wire

// ===== rtl/core/ufwf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ufwf_ctrl
// Controller: protocol phase tracking and result sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufwf_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [1:0]              req_operation,
   input  wire logic                    req_last_of_image,
   input  wire ufwf_pkg::ufwf_stat_type stat,
   output ufwf_pkg::ufwf_cmd_type       cmd
);
   import ufwf_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CMD1 = 3'd1;
   localparam logic [2:0] S_ADR2 = 3'd2;
   localparam logic [2:0] S_ADR1 = 3'd3;
   localparam logic [2:0] S_ADR0 = 3'd4;
   localparam logic [2:0] S_AXOR = 3'd5;
   localparam logic [2:0] S_DATA = 3'd6;
   localparam logic [2:0] S_SUM  = 3'd7;

   // protocol phases
   localparam logic [2:0] PH_GATHER    = 3'd0;
   localparam logic [2:0] PH_WAIT_CMD  = 3'd1;
   localparam logic [2:0] PH_WAIT_ADDR = 3'd2;
   localparam logic [2:0] PH_WAIT_DATA = 3'd3;
   localparam logic [2:0] PH_ERROR     = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] phase_ff, phase_in;
   logic       accept;

   // take a transaction only when idle with a free output stage
   assign req_stall = ~((state_ff == S_IDLE) & stat.out_free);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      cmd            = '0;
      cmd.out_sel    = SEL_NONE;
      cmd.out_status = ST_SENDING;
      case (state_ff)
         // decode a new transaction, its first result (if it has one) goes out at once
         S_IDLE: begin
            if (accept) begin
               if (req_operation == OP_START) begin
                  cmd.start      = 1'b1;
                  phase_in       = PH_GATHER;
                  cmd.out_load   = 1'b1;
                  cmd.out_status = ST_ACCEPTED;
                  cmd.out_last   = 1'b1;
               end else if (req_operation != OP_IMAGE && req_operation != OP_REPLY) begin
                  cmd.out_load = 1'b0;
               end else if (phase_ff == PH_ERROR) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_status = ST_ERROR;
                  cmd.out_last   = 1'b1;
               end else if (req_operation == OP_IMAGE) begin
                  cmd.out_load = 1'b1;
                  if (phase_ff != PH_GATHER) begin
                     cmd.out_status = ST_BUSY;
                     cmd.out_last   = 1'b1;
                  end else begin
                     cmd.store = 1'b1;
                     if (stat.chunk_full || req_last_of_image) begin
                        cmd.set_final = 1'b1;
                        phase_in      = PH_WAIT_CMD;
                        cmd.out_sel   = SEL_OPC;
                        state_in      = S_CMD1;
                     end else begin
                        cmd.out_status = ST_ACCEPTED;
                        cmd.out_last   = 1'b1;
                     end
                  end
               end else begin
                  cmd.out_load = 1'b1;
                  if (phase_ff == PH_GATHER) begin
                     cmd.out_status = ST_ACCEPTED;
                     cmd.out_last   = 1'b1;
                  end else if (!stat.ack_match) begin
                     phase_in       = PH_ERROR;
                     cmd.out_status = ST_ERROR;
                     cmd.out_last   = 1'b1;
                  end else if (phase_ff == PH_WAIT_CMD) begin
                     phase_in    = PH_WAIT_ADDR;
                     cmd.out_sel = SEL_A3;
                     state_in    = S_ADR2;
                  end else if (phase_ff == PH_WAIT_ADDR) begin
                     phase_in     = PH_WAIT_DATA;
                     cmd.out_sel  = SEL_NM1;
                     cmd.sum_init = 1'b1;
                     state_in     = S_DATA;
                  end else begin
                     cmd.advance    = 1'b1;
                     phase_in       = PH_GATHER;
                     cmd.out_status = stat.final_chunk ? ST_DONE : ST_CHUNK;
                     cmd.out_last   = 1'b1;
                  end
               end
            end
         end
         // command complement
         S_CMD1: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_NOPC;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         // remaining address bytes and their xor
         S_ADR2: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_A2;
               state_in     = S_ADR1;
            end
         end
         S_ADR1: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_A1;
               state_in     = S_ADR0;
            end
         end
         S_ADR0: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_A0;
               state_in     = S_AXOR;
            end
         end
         S_AXOR: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_AXOR;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         // stream chunk bytes from the store
         S_DATA: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_DATA;
               cmd.sum_acc  = 1'b1;
               if (stat.data_last) begin
                  cmd.idx_clear = 1'b1;
                  state_in      = S_SUM;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         // data checksum
         S_SUM: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_SUM;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_GATHER;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   // command complement only follows the command of a chunk
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMD1) |-> (phase_ff == PH_WAIT_CMD))
      else $error("command sequence outside command phase");

   // address bytes belong to the address phase
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADR2 || state_ff == S_ADR1 || state_ff == S_ADR0 ||
       state_ff == S_AXOR) |-> (phase_ff == PH_WAIT_ADDR))
      else $error("address sequence outside address phase");

   // data streaming belongs to the data phase
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DATA || state_ff == S_SUM) |-> (phase_ff == PH_WAIT_DATA))
      else $error("data sequence outside data phase");

endmodule

`default_nettype wire

// ===== rtl/core/uart_flash_write_framer.sv =====
// ----------------------------------------------------------------------------
// uart_flash_write_framer
// Host side framer for a serial flash write memory sequence.
// ----------------------------------------------------------------------------
// Image bytes are collected into a chunk store; once a chunk is full (or the
// image ends) the block emits the write command and its complement, and each
// acknowledge reply then releases the next stage of the sequence: four
// address bytes plus their xor, then N-1, the N data bytes and a checksum,
// and finally a chunk written or image done status. One transaction is taken
// when the sequencer is idle and the output register is free, and its first
// result is loaded in the same cycle; every further result is loaded once the
// output register is free again, and the data stage streams the chunk RAM
// one byte per cycle while the result side does not stall. Stalls on the
// result side hold the sequence. The chunk store needs no clearing after
// reset, so the block is ready right away.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uart_flash_write_framer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // input channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_operation,
   input  wire logic [7:0]                  req_data_byte,
   input  wire logic                        req_last_of_image,
   // result channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [7:0]                       rsp_tx_byte,
   output logic                             rsp_tx_valid,
   output logic [2:0]                       rsp_status,
   output logic                             rsp_last_result,
   // csr port
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [ufwf_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [ufwf_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [ufwf_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                             csr_pready
);
   import ufwf_pkg::*;

   ufwf_cmd_type     cmd;
   ufwf_stat_type    stat;
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [7:0]       ram_wr_data;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [7:0]       ram_rd_data;

   // sequencer
   ufwf_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_last_of_image (req_last_of_image),
      .stat              (stat),
      .cmd               (cmd)
   );

   // registers, counters and output stage
   ufwf_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_data_byte     (req_data_byte),
      .req_last_of_image (req_last_of_image),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_tx_valid      (rsp_tx_valid),
      .rsp_status        (rsp_status),
      .rsp_last_result   (rsp_last_result),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // chunk store
   ufwf_ram #(
      .WIDTH (8),
      .DEPTH (MAX_CHUNK)
   ) u_chunk_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

// ===== tb/tb_uart_flash_write_framer.sv =====
// ----------------------------------------------------------------------------
// tb_uart_flash_write_framer
// Self-checking bench for the serial flash write framer.
// ----------------------------------------------------------------------------
// A short table of directed transactions runs first. Where a row's outcome is
// obvious it carries a typed status; all other rows use the bench's own model
// of the write sequence. A random part follows. It mostly runs well-formed
// image sessions (start, bytes, three acknowledges per chunk) and mixes in
// busy bytes, bad replies, ignored operations and replies while gathering.
// Register settings change between sessions only when the block is drained.
// Sender gaps and receiver stalls follow several idling profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uart_flash_write_framer;
   import ufwf_pkg::*;

   localparam int          CYCLE_LIMIT  = 3_000_000;
   localparam int          RANDOM_ITEMS = 430;
   localparam int          SETTLE       = 100;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;

   typedef enum logic [2:0] {
      FR_GATHER, FR_WAIT_CMD, FR_WAIT_ADDR, FR_WAIT_DATA, FR_ERROR
   } framer_phase_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic [2:0] status;
      logic       last_result;
   } tx_beat_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data;
      logic       last;
      logic       typed;
      logic [2:0] status;
   } stim_row_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   // dut ports
   logic                req_valid         = 1'b0;
   logic                req_stall;
   logic [1:0]          req_operation     = '0;
   logic [7:0]          req_data_byte     = '0;
   logic                req_last_of_image = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall         = 1'b0;
   logic [7:0]          rsp_tx_byte;
   logic                rsp_tx_valid;
   logic [2:0]          rsp_status;
   logic                rsp_last_result;
   logic                csr_psel          = 1'b0;
   logic                csr_penable       = 1'b0;
   logic                csr_pwrite        = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr         = '0;
   logic [CSR_DW-1:0]   csr_pwdata        = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   uart_flash_write_framer uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_data_byte     (req_data_byte),
      .req_last_of_image (req_last_of_image),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_tx_valid      (rsp_tx_valid),
      .rsp_status        (rsp_status),
      .rsp_last_result   (rsp_last_result),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // framer model state and settings
   logic [31:0]      set_start_addr;
   logic [5:0]       set_chunk_size;
   logic [7:0]       set_ack;
   logic [7:0]       set_opcode;
   logic [7:0]       chunk_mem [MAX_CHUNK];
   int               fill;
   framer_phase_type fr_phase;
   logic [31:0]      flash_addr;
   logic             final_flag;

   tx_beat_type item_beats [$];
   tx_beat_type tx_expect_q [$];

   // run bookkeeping
   int fail_count   = 0;
   int cycle_count  = 0;
   int n_items      = 0;
   int n_results    = 0;
   int n_completed  = 0;
   int n_csr_writes = 0;
   int sender_pct   = 0;
   int stall_pct    = 0;

   function automatic void add_beat(logic [7:0] b, logic v, logic [2:0] st);
      item_beats.push_back('{tx_byte: v ? b : 8'h00, tx_valid: v, status: st,
                             last_result: 1'b0});
   endfunction

   // next state and result bytes of the write sequence for one transaction
   task automatic frame_model_step(input logic [1:0] op, input logic [7:0] d,
                                   input logic lst);
      int          lim;
      logic [7:0]  a3, a2, a1, a0, nm1, sum;
      tx_beat_type tail;
      item_beats.delete();
      lim = (set_chunk_size == 0) ? 1 :
            (set_chunk_size > MAX_CHUNK) ? MAX_CHUNK : int'(set_chunk_size);
      if (op == OP_START) begin
         flash_addr = set_start_addr;
         fill       = 0;
         final_flag = 1'b0;
         fr_phase   = FR_GATHER;
         add_beat(8'h00, 1'b0, ST_ACCEPTED);
      end else if (op == OP_UNUSED) begin
         // dropped without a result
      end else if (fr_phase == FR_ERROR) begin
         add_beat(8'h00, 1'b0, ST_ERROR);
      end else if (op == OP_IMAGE) begin
         if (fr_phase != FR_GATHER) begin
            add_beat(8'h00, 1'b0, ST_BUSY);
         end else begin
            if (fill < MAX_CHUNK) begin
               chunk_mem[fill] = d;
               fill++;
            end
            if (fill >= lim || lst) begin
               final_flag = lst;
               fr_phase   = FR_WAIT_CMD;
               add_beat(set_opcode, 1'b1, ST_SENDING);
               add_beat(~set_opcode, 1'b1, ST_SENDING);
            end else begin
               add_beat(8'h00, 1'b0, ST_ACCEPTED);
            end
         end
      end else begin
         // reply byte from the target
         if (fr_phase == FR_GATHER) begin
            add_beat(8'h00, 1'b0, ST_ACCEPTED);
         end else if (d != set_ack) begin
            fr_phase = FR_ERROR;
            add_beat(8'h00, 1'b0, ST_ERROR);
         end else if (fr_phase == FR_WAIT_CMD) begin
            a3 = flash_addr[31:24];
            a2 = flash_addr[23:16];
            a1 = flash_addr[15:8];
            a0 = flash_addr[7:0];
            add_beat(a3, 1'b1, ST_SENDING);
            add_beat(a2, 1'b1, ST_SENDING);
            add_beat(a1, 1'b1, ST_SENDING);
            add_beat(a0, 1'b1, ST_SENDING);
            add_beat(a3 ^ a2 ^ a1 ^ a0, 1'b1, ST_SENDING);
            fr_phase = FR_WAIT_ADDR;
         end else if (fr_phase == FR_WAIT_ADDR) begin
            nm1 = 8'(fill - 1);
            sum = nm1;
            add_beat(nm1, 1'b1, ST_SENDING);
            for (int i = 0; i < fill; i++) begin
               sum ^= chunk_mem[i];
               add_beat(chunk_mem[i], 1'b1, ST_SENDING);
            end
            add_beat(sum, 1'b1, ST_SENDING);
            fr_phase = FR_WAIT_DATA;
         end else begin
            flash_addr = flash_addr + 32'(fill);
            fill       = 0;
            fr_phase   = FR_GATHER;
            add_beat(8'h00, 1'b0, final_flag ? ST_DONE : ST_CHUNK);
            final_flag = 1'b0;
         end
      end
      if (item_beats.size() > 0) begin
         tail = item_beats.pop_back();
         tail.last_result = 1'b1;
         item_beats.push_back(tail);
      end
   endtask

   function automatic int pick_gap(int pct);
      int g = 0;
      while (g < 40 && $urandom_range(99) < pct) g++;
      return g;
   endfunction

   // drive one transaction and record what it should produce
   task automatic send_item(input logic [1:0] op, input logic [7:0] d, input logic lst,
                            input logic typed, input logic [2:0] st);
      int gap;
      gap = pick_gap(sender_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_operation     <= op;
      req_data_byte     <= d;
      req_last_of_image <= lst;
      req_valid         <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      frame_model_step(op, d, lst);
      if (typed) begin
         item_beats.delete();
         item_beats.push_back('{tx_byte: 8'h00, tx_valid: 1'b0, status: st,
                                last_result: 1'b1});
      end
      foreach (item_beats[i]) tx_expect_q.push_back(item_beats[i]);
      n_items++;
   endtask

   // hold the sender until every expected result is out, then let it settle
   task automatic drain;
      req_valid <= 1'b0;
      while (tx_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // one write transfer, after which the bus returns to idle
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_START_ADDRESS: set_start_addr = value;
         REG_CHUNK_SIZE:    set_chunk_size = value[5:0];
         REG_ACK_CODE:      set_ack        = value[7:0];
         REG_WRITE_OPCODE:  set_opcode     = value[7:0];
         default: ;
      endcase
      n_csr_writes++;
      @(posedge clock);
   endtask

   // one read transfer, after which the bus returns to idle
   task automatic csr_check(input logic [1:0] idx, input logic [31:0] want);
      logic [31:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== want) begin
         $error("csr reg %0d: expected %0h, got %0h", idx, want, got);
         fail_count++;
      end
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [31:0] addr, input logic [5:0] size,
                                 input logic [7:0] ack, input logic [7:0] opc);
      csr_write(REG_START_ADDRESS, addr);
      csr_write(REG_CHUNK_SIZE, {26'd0, size});
      csr_write(REG_ACK_CODE, {24'd0, ack});
      csr_write(REG_WRITE_OPCODE, {24'd0, opc});
      csr_check(REG_START_ADDRESS, addr);
      csr_check(REG_CHUNK_SIZE, {26'd0, size});
      csr_check(REG_ACK_CODE, {24'd0, ack});
      csr_check(REG_WRITE_OPCODE, {24'd0, opc});
   endtask

   task automatic set_idling(input int mode);
      case (mode % 4)
         0: begin sender_pct = 0;  stall_pct = 0;  end
         1: begin sender_pct = 86; stall_pct = 0;  end
         2: begin sender_pct = 0;  stall_pct = 86; end
         default: begin sender_pct = 28; stall_pct = 28; end
      endcase
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < stall_pct);
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin : check_results
      tx_beat_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (tx_expect_q.size() == 0) begin
            $error("unexpected result: tx_byte %0h status %0d", rsp_tx_byte, rsp_status);
            fail_count++;
         end else begin
            want = tx_expect_q.pop_front();
            n_results++;
            if (want.status == ST_CHUNK || want.status == ST_DONE) n_completed++;
            if (rsp_tx_byte !== want.tx_byte) begin
               $error("tx_byte: expected %0h, got %0h", want.tx_byte, rsp_tx_byte);
               fail_count++;
            end
            if (rsp_tx_valid !== want.tx_valid) begin
               $error("tx_valid: expected %0b, got %0b", want.tx_valid, rsp_tx_valid);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_last_result !== want.last_result) begin
               $error("last_result: expected %0b, got %0b", want.last_result,
                      rsp_last_result);
               fail_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // directed rows at the reset settings
   localparam int N_ROWS = 24;
   stim_row_type dir_rows [N_ROWS] = '{
      // reply while gathering is ignored
      '{OP_REPLY,  8'h79, 1'b0, 1'b1, ST_ACCEPTED},
      '{OP_UNUSED, 8'h00, 1'b0, 1'b0, ST_ACCEPTED},
      '{OP_IMAGE,  8'h00, 1'b0, 1'b0, ST_ACCEPTED},
      // short final chunk, address still zero before any start
      '{OP_IMAGE,  8'hFF, 1'b1, 1'b0, ST_ACCEPTED},
      '{OP_IMAGE,  8'hA5, 1'b0, 1'b1, ST_BUSY},
      '{OP_REPLY,  8'h79, 1'b0, 1'b0, ST_ACCEPTED},
      '{OP_REPLY,  8'h79, 1'b0, 1'b0, ST_ACCEPTED},
      '{OP_REPLY,  8'h79, 1'b0, 1'b0, ST_ACCEPTED},
      '{OP_START,  8'h00, 1'b0, 1'b1, ST_ACCEPTED},
      // full chunk of six
      '{OP_IMAGE,  8'h80, 1'b0, 1'b0, ST_ACCEPTED},
      '{OP_IMAGE,  8'h01, 1'b0, 1'b0, ST_ACCEPTED},
      '{OP_IMAGE,  8'h7F, 1'b0, 1'b0, ST_ACCEPTED},
      '{OP_IMAGE,  8'hFE, 1'b0, 1'b0, ST_ACCEPTED},
      '{OP_IMAGE,  8'h55, 1'b0, 1'b0, ST_ACCEPTED},
      '{OP_IMAGE,  8'hAA, 1'b0, 1'b0, ST_ACCEPTED},
      '{OP_REPLY,  8'h79, 1'b0, 1'b0, ST_ACCEPTED},
      '{OP_REPLY,  8'h79, 1'b0, 1'b0, ST_ACCEPTED},
      '{OP_REPLY,  8'h79, 1'b0, 1'b0, ST_ACCEPTED},
      // nack, then images and replies report the error; unused is dropped, start recovers
      '{OP_IMAGE,  8'h12, 1'b1, 1'b0, ST_ACCEPTED},
      '{OP_REPLY,  8'h00, 1'b0, 1'b1, ST_ERROR},
      '{OP_IMAGE,  8'h33, 1'b0, 1'b1, ST_ERROR},
      '{OP_REPLY,  8'h79, 1'b0, 1'b1, ST_ERROR},
      '{OP_UNUSED, 8'hFF, 1'b1, 1'b0, ST_ACCEPTED},
      '{OP_START,  8'hFF, 1'b1, 1'b1, ST_ACCEPTED}
   };

   // main sequence
   initial begin : stimulus
      int          rand_count;
      int          next_cfg_at;
      int          cfg_round;
      int          r;
      logic [31:0] addr;
      logic [5:0]  size;

      set_start_addr = RST_START_ADDRESS;
      set_chunk_size = RST_CHUNK_SIZE;
      set_ack        = RST_ACK_CODE;
      set_opcode     = RST_WRITE_OPCODE;
      fill           = 0;
      fr_phase       = FR_GATHER;
      flash_addr     = 32'h0;
      final_flag     = 1'b0;
      rand_count     = 0;
      next_cfg_at    = 0;
      cfg_round      = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register reset values
      csr_check(REG_START_ADDRESS, RST_START_ADDRESS);
      csr_check(REG_CHUNK_SIZE, {26'd0, RST_CHUNK_SIZE});
      csr_check(REG_ACK_CODE, {24'd0, RST_ACK_CODE});
      csr_check(REG_WRITE_OPCODE, {24'd0, RST_WRITE_OPCODE});

      set_idling(0);
      foreach (dir_rows[i]) begin
         send_item(dir_rows[i].op, dir_rows[i].data, dir_rows[i].last,
                   dir_rows[i].typed, dir_rows[i].status);
      end

      // random sessions
      while (rand_count < RANDOM_ITEMS) begin
         if (rand_count >= next_cfg_at && fr_phase == FR_GATHER) begin
            drain();
            case (cfg_round)
               0: apply_settings(32'hFFFF_FFFF, 6'd63, 8'h00, 8'hFF);
               1: apply_settings(32'h0000_0000, 6'd0, 8'hFF, 8'h00);
               2: apply_settings(32'hFFFF_FFF0, 6'd1, 8'h79, 8'h31);
               3: apply_settings($urandom, 6'd62, 8'($urandom), 8'($urandom));
               default: begin
                  r    = $urandom_range(99);
                  addr = (r < 15) ? 32'hFFFF_FFFF : (r < 30) ? 32'h0 : $urandom;
                  r    = $urandom_range(99);
                  size = (r < 75) ? 6'($urandom_range(8, 1)) :
                         (r < 85) ? 6'd0 : (r < 92) ? 6'd63 : 6'($urandom);
                  apply_settings(addr, size, 8'($urandom), 8'($urandom));
               end
            endcase
            set_idling(cfg_round);
            cfg_round++;
            next_cfg_at += 55;
            send_item(OP_START, 8'($urandom), 1'($urandom), 1'b0, ST_ACCEPTED);
            rand_count++;
         end

         r = $urandom_range(99);
         if (r < 3) begin
            // unused operation is dropped
            send_item(OP_UNUSED, 8'($urandom), 1'($urandom), 1'b0, ST_ACCEPTED);
         end else if (fr_phase == FR_GATHER) begin
            if (r < 7) begin
               send_item(OP_START, 8'($urandom), 1'($urandom), 1'b0, ST_ACCEPTED);
               rand_count++;
            end else if (r < 10) begin
               send_item(OP_REPLY, 8'($urandom), 1'($urandom), 1'b0, ST_ACCEPTED);
            end else begin
               send_item(OP_IMAGE, 8'($urandom), ($urandom_range(15) == 0), 1'b0,
                         ST_ACCEPTED);
               rand_count++;
            end
         end else if (fr_phase == FR_ERROR) begin
            if (r < 60) begin
               send_item(OP_START, 8'($urandom), 1'($urandom), 1'b0, ST_ACCEPTED);
            end else begin
               send_item(2'($urandom_range(1)), 8'($urandom), 1'($urandom), 1'b0,
                         ST_ACCEPTED);
            end
            rand_count++;
         end else begin
            // waiting for an acknowledge
            if (r < 90) begin
               send_item(OP_REPLY, set_ack, 1'($urandom), 1'b0, ST_ACCEPTED);
            end else if (r < 95) begin
               send_item(OP_IMAGE, 8'($urandom), 1'($urandom), 1'b0, ST_ACCEPTED);
            end else begin
               send_item(OP_REPLY, 8'($urandom), 1'($urandom), 1'b0, ST_ACCEPTED);
            end
            rand_count++;
         end
      end

      drain();
      $display("summary: %0d transactions in, %0d results checked, %0d chunks finished",
               n_items, n_results, n_completed);
      $display("summary: %0d register writes over %0d settings", n_csr_writes, cfg_round);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
